// ===== rtl/sveu_pkg.sv =====
// ----------------------------------------------------------------------------
// sveu_pkg: shared types and constants of the script variable execute unit
// Action codes, condition codes, the decoded instruction and slot mapping.
// ----------------------------------------------------------------------------
package sveu_pkg;

    localparam int VAR_COUNT   = 256;
    localparam int STACK_DEPTH = 256;
    localparam int QUEUE_DEPTH = 2;

    localparam int VAR_AW = $clog2(VAR_COUNT);
    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int QUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUE_CW = $clog2(QUEUE_DEPTH + 1);

    // Reciprocals scaled by 2^16, rounded up; exact for any 8-bit index.
    localparam int VAR_RECIP = (65536 + VAR_COUNT - 1) / VAR_COUNT;
    localparam int STK_RECIP = (65536 + STACK_DEPTH - 1) / STACK_DEPTH;

    localparam logic [VAR_AW-1:0] VAR_INIT_SLOT = VAR_AW'(8'h54 % VAR_COUNT);
    localparam logic [15:0]       VAR_INIT_VAL  = 16'h0081;

    typedef enum logic [3:0] {
        ACT_SET       = 4'd0,
        ACT_COPY      = 4'd1,
        ACT_ADD       = 4'd2,
        ACT_ADDIMM    = 4'd3,
        ACT_SUB       = 4'd4,
        ACT_AND       = 4'd5,
        ACT_OR        = 4'd6,
        ACT_SHL       = 4'd7,
        ACT_SHR       = 4'd8,
        ACT_DECBRANCH = 4'd9,
        ACT_CMPBRANCH = 4'd10,
        ACT_JUMP      = 4'd11,
        ACT_CALL      = 4'd12,
        ACT_RET       = 4'd13,
        ACT_START     = 4'd14,
        ACT_READ      = 4'd15
    } t_action;

    typedef enum logic [2:0] {
        COND_EQ = 3'd0,
        COND_NE = 3'd1,
        COND_GT = 3'd2,
        COND_GE = 3'd3,
        COND_LT = 3'd4,
        COND_LE = 3'd5
    } t_cond;

    typedef struct packed {
        t_action           action;
        logic [VAR_AW-1:0] dst;
        logic [VAR_AW-1:0] src;
        logic [15:0]       imm;
        logic [2:0]        cond;
        logic              with_var;
        logic [15:0]       target;
        logic [15:0]       ret_off;
        logic              bad_cond;
        logic              shift_big;
        logic [3:0]        shamt;
        logic              writes_var;
        logic              shows_value;
    } t_op;

    function automatic logic [VAR_AW-1:0] var_slot(input logic [7:0] idx);
        logic [23:0] prod;
        logic [9:0]  rem;
        prod = 24'(idx) * 24'(VAR_RECIP);
        rem  = 10'(idx) - 10'(prod[23:16]) * 10'(VAR_COUNT);
        return rem[VAR_AW-1:0];
    endfunction

    function automatic logic [STK_AW-1:0] stk_slot(input logic [7:0] ptr);
        logic [23:0] prod;
        logic [9:0]  rem;
        prod = 24'(ptr) * 24'(STK_RECIP);
        rem  = 10'(ptr) - 10'(prod[23:16]) * 10'(STACK_DEPTH);
        return rem[STK_AW-1:0];
    endfunction

endpackage

// ===== rtl/sveu_ram.sv =====
// ----------------------------------------------------------------------------
// sveu_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sveu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sveu_front.sv =====
// ----------------------------------------------------------------------------
// sveu_front: instruction intake and classification
// Maps indexes to slots, flags special cases and holds a short item queue.
// ----------------------------------------------------------------------------
module sveu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [3:0]         i_action,
    input  logic [7:0]         i_dest_index,
    input  logic [7:0]         i_src_index,
    input  logic signed [15:0] i_immediate,
    input  logic [2:0]         i_cond_code,
    input  logic               i_compare_with_var,
    input  logic [15:0]        i_target,
    input  logic [15:0]        i_return_offset,
    output logic               o_op_valid,
    output sveu_pkg::t_op      o_op,
    input  logic               i_op_take
);

    sveu_pkg::t_op                    r_q [sveu_pkg::QUEUE_DEPTH];
    logic [sveu_pkg::QUE_AW-1:0]      r_wr_ptr;
    logic [sveu_pkg::QUE_AW-1:0]      r_rd_ptr;
    logic [sveu_pkg::QUE_CW-1:0]      r_count;
    sveu_pkg::t_op                    n_op;
    logic                             accept;
    logic                             take;

    assign o_full     = (r_count == sveu_pkg::QUE_CW'(sveu_pkg::QUEUE_DEPTH));
    assign o_op_valid = (r_count != '0);
    assign o_op       = r_q[r_rd_ptr];
    assign accept     = i_push && !o_full;
    assign take       = i_op_take && o_op_valid;

    always_comb begin
        n_op             = '0;
        n_op.action      = sveu_pkg::t_action'(i_action);
        n_op.dst         = sveu_pkg::var_slot(i_dest_index);
        n_op.src         = sveu_pkg::var_slot(i_src_index);
        n_op.imm         = i_immediate;
        n_op.cond        = i_cond_code;
        n_op.with_var    = i_compare_with_var;
        n_op.target      = i_target;
        n_op.ret_off     = i_return_offset;
        n_op.bad_cond    = (n_op.action == sveu_pkg::ACT_CMPBRANCH)
                           && (i_cond_code > sveu_pkg::COND_LE);
        // Any set bit above the low four means a shift of 16 or more.
        n_op.shift_big   = (i_immediate[15:4] != '0);
        n_op.shamt       = i_immediate[3:0];
        n_op.writes_var  = (n_op.action <= sveu_pkg::ACT_DECBRANCH);
        n_op.shows_value = n_op.writes_var || (n_op.action == sveu_pkg::ACT_READ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_q[r_wr_ptr] <= n_op;
                r_wr_ptr      <= r_wr_ptr + 1'b1;
            end
            if (take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (accept && !take) begin
                r_count <= r_count + 1'b1;
            end else if (take && !accept) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sveu_pkg::QUE_CW'(sveu_pkg::QUEUE_DEPTH))
        else $error("front queue count exceeds its depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !take |=> r_count == $past(r_count) + 1'b1)
        else $error("front queue lost an accepted item");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !accept |=> r_count == $past(r_count) - 1'b1)
        else $error("front queue count did not drop on take");

endmodule

// ===== rtl/sveu_back.sv =====
// ----------------------------------------------------------------------------
// sveu_back: instruction execution
// Reads the variable file and call stack, computes, writes back and presents
// the result item in an output register.
// ----------------------------------------------------------------------------
module sveu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  sveu_pkg::t_op i_op,
    output logic          o_op_take,
    output logic          o_empty,
    input  logic          i_pop,
    output logic          o_branch_taken,
    output logic [15:0]   o_next_offset,
    output logic [15:0]   o_var_value,
    output logic          o_bad_condition
);

    typedef enum logic {
        S_ISSUE,
        S_EXEC
    } t_state;

    t_state                       r_state;
    sveu_pkg::t_op                r_ins;
    logic [sveu_pkg::VAR_COUNT-1:0] r_valid;
    logic [7:0]                   r_sp;
    logic                         r_out_valid;
    logic                         r_out_taken;
    logic [15:0]                  r_out_next;
    logic [15:0]                  r_out_value;
    logic                         r_out_bad;

    logic                         n_taken;
    logic [15:0]                  n_next;
    logic [15:0]                  n_value;
    logic [15:0]                  n_result;

    logic [sveu_pkg::VAR_AW-1:0]  rd_dst;
    logic [sveu_pkg::VAR_AW-1:0]  rd_src;
    logic [15:0]                  ram_dst;
    logic [15:0]                  ram_src;
    logic [15:0]                  stk_data;
    logic [15:0]                  val_dst;
    logic [15:0]                  val_src;
    logic signed [15:0]           cmp_l;
    logic signed [15:0]           cmp_r;
    logic                         cmp_eq;
    logic                         cmp_lt;
    logic                         cmp_hit;
    logic                         pop_ok;
    logic                         exec_done;
    logic                         var_we;
    logic                         stk_we;

    assign pop_ok    = i_pop && r_out_valid;
    assign o_op_take = (r_state == S_ISSUE) && i_op_valid;
    assign exec_done = (r_state == S_EXEC) && (!r_out_valid || i_pop);
    assign var_we    = exec_done && r_ins.writes_var;
    assign stk_we    = exec_done && (r_ins.action == sveu_pkg::ACT_CALL);

    // Reads are issued from the queue head and held steady while stalled.
    assign rd_dst = (r_state == S_ISSUE) ? i_op.dst : r_ins.dst;
    assign rd_src = (r_state == S_ISSUE) ? i_op.src : r_ins.src;

    sveu_ram #(.WIDTH(16), .DEPTH(sveu_pkg::VAR_COUNT)) u_var_dst (
        .i_clk   (i_clk),
        .i_we    (var_we),
        .i_waddr (r_ins.dst),
        .i_wdata (n_result),
        .i_raddr (rd_dst),
        .o_rdata (ram_dst)
    );

    sveu_ram #(.WIDTH(16), .DEPTH(sveu_pkg::VAR_COUNT)) u_var_src (
        .i_clk   (i_clk),
        .i_we    (var_we),
        .i_waddr (r_ins.dst),
        .i_wdata (n_result),
        .i_raddr (rd_src),
        .o_rdata (ram_src)
    );

    sveu_ram #(.WIDTH(16), .DEPTH(sveu_pkg::STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (sveu_pkg::stk_slot(r_sp)),
        .i_wdata (r_ins.ret_off),
        .i_raddr (sveu_pkg::stk_slot(r_sp - 8'd1)),
        .o_rdata (stk_data)
    );

    // An entry never written since reset reads as its reset value.
    assign val_dst = r_valid[r_ins.dst] ? ram_dst :
                     ((r_ins.dst == sveu_pkg::VAR_INIT_SLOT) ? sveu_pkg::VAR_INIT_VAL : '0);
    assign val_src = r_valid[r_ins.src] ? ram_src :
                     ((r_ins.src == sveu_pkg::VAR_INIT_SLOT) ? sveu_pkg::VAR_INIT_VAL : '0);

    assign cmp_l  = val_dst;
    assign cmp_r  = r_ins.with_var ? val_src : r_ins.imm;
    assign cmp_eq = (cmp_l == cmp_r);
    assign cmp_lt = (cmp_l < cmp_r);

    always_comb begin
        case (r_ins.cond)
            sveu_pkg::COND_EQ: cmp_hit = cmp_eq;
            sveu_pkg::COND_NE: cmp_hit = !cmp_eq;
            sveu_pkg::COND_GT: cmp_hit = !cmp_eq && !cmp_lt;
            sveu_pkg::COND_GE: cmp_hit = !cmp_lt;
            sveu_pkg::COND_LT: cmp_hit = cmp_lt;
            sveu_pkg::COND_LE: cmp_hit = cmp_lt || cmp_eq;
            default:           cmp_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_result = val_dst;
        n_taken  = 1'b0;
        n_next   = r_ins.target;
        case (r_ins.action)
            sveu_pkg::ACT_SET:    n_result = r_ins.imm;
            sveu_pkg::ACT_COPY:   n_result = val_src;
            sveu_pkg::ACT_ADD:    n_result = val_dst + val_src;
            sveu_pkg::ACT_ADDIMM: n_result = val_dst + r_ins.imm;
            sveu_pkg::ACT_SUB:    n_result = val_dst - val_src;
            sveu_pkg::ACT_AND:    n_result = val_dst & r_ins.imm;
            sveu_pkg::ACT_OR:     n_result = val_dst | r_ins.imm;
            sveu_pkg::ACT_SHL: begin
                n_result = r_ins.shift_big ? '0 : (val_dst << r_ins.shamt);
            end
            sveu_pkg::ACT_SHR: begin
                n_result = r_ins.shift_big ? {16{val_dst[15]}}
                                           : 16'($signed(val_dst) >>> r_ins.shamt);
            end
            sveu_pkg::ACT_DECBRANCH: begin
                n_result = val_dst - 16'd1;
                n_taken  = (n_result != '0);
            end
            sveu_pkg::ACT_CMPBRANCH: n_taken = cmp_hit;
            sveu_pkg::ACT_JUMP:      n_taken = 1'b1;
            sveu_pkg::ACT_CALL:      n_taken = 1'b1;
            sveu_pkg::ACT_RET: begin
                n_taken = 1'b1;
                n_next  = stk_data;
            end
            default: n_taken = 1'b0;
        endcase
        n_value = r_ins.shows_value ? n_result : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ISSUE;
            r_valid     <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_ISSUE: begin
                    if (i_op_valid) begin
                        r_ins   <= i_op;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_done) begin
                        r_state <= S_ISSUE;
                    end
                end
                default: r_state <= S_ISSUE;
            endcase

            if (exec_done) begin
                r_out_valid <= 1'b1;
                r_out_taken <= n_taken;
                r_out_next  <= n_taken ? n_next : '0;
                r_out_value <= n_value;
                r_out_bad   <= r_ins.bad_cond;
                if (r_ins.writes_var) begin
                    r_valid[r_ins.dst] <= 1'b1;
                end
                case (r_ins.action)
                    sveu_pkg::ACT_CALL:  r_sp <= r_sp + 8'd1;
                    sveu_pkg::ACT_RET:   r_sp <= r_sp - 8'd1;
                    sveu_pkg::ACT_START: r_sp <= '0;
                    default:             r_sp <= r_sp;
                endcase
            end else if (pop_ok) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_branch_taken  = r_out_taken;
    assign o_next_offset   = r_out_next;
    assign o_var_value     = r_out_value;
    assign o_bad_condition = r_out_bad;

    a_call_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_done && (r_ins.action == sveu_pkg::ACT_CALL) |=> r_sp == $past(r_sp) + 8'd1)
        else $error("call did not advance the stack pointer");

    a_ret_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_done && (r_ins.action == sveu_pkg::ACT_RET) |=> r_sp == $past(r_sp) - 8'd1)
        else $error("return did not step back the stack pointer");

    a_load_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(r_state) == S_EXEC)
        else $error("result item loaded outside the execute step");

endmodule

// ===== rtl/script_variable_execute_unit.sv =====
// ----------------------------------------------------------------------------
// script_variable_execute_unit: execute unit of a bytecode machine
// Runs pre-decoded instructions against a 256-entry variable file and a
// call stack, giving one result item per instruction.
// ----------------------------------------------------------------------------
// Each instruction passes S_ISSUE, which reads the variable file (two ports)
// and the call stack, then S_EXEC, which computes, writes back and loads the
// result register, stalling while it holds an unpopped item. No instruction
// issues until the last leaves S_EXEC, because of the read-then-write loop on
// the variable file. A push is queued, issued, executed and shown in the
// result register (empty low). A two-item queue in front lets pushes
// continue while the result register waits to be popped. The variable file
// comes out of reset ready at once: per-entry valid bits make unwritten
// entries read as zero, or 0x81 for entry 0x54, so there is no clearing pass.
module script_variable_execute_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         i_action,
    input  logic [7:0]         i_dest_index,
    input  logic [7:0]         i_src_index,
    input  logic signed [15:0] i_immediate,
    input  logic [2:0]         i_cond_code,
    input  logic               i_compare_with_var,
    input  logic [15:0]        i_target,
    input  logic [15:0]        i_return_offset,
    output logic               empty,
    input  logic               pop,
    output logic               o_branch_taken,
    output logic [15:0]        o_next_offset,
    output logic signed [15:0] o_var_value,
    output logic               o_bad_condition
);

    logic          op_valid;
    logic          op_take;
    sveu_pkg::t_op op;
    logic [15:0]   var_value;

    sveu_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .o_full             (full),
        .i_action           (i_action),
        .i_dest_index       (i_dest_index),
        .i_src_index        (i_src_index),
        .i_immediate        (i_immediate),
        .i_cond_code        (i_cond_code),
        .i_compare_with_var (i_compare_with_var),
        .i_target           (i_target),
        .i_return_offset    (i_return_offset),
        .o_op_valid         (op_valid),
        .o_op               (op),
        .i_op_take          (op_take)
    );

    sveu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_valid      (op_valid),
        .i_op            (op),
        .o_op_take       (op_take),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_branch_taken  (o_branch_taken),
        .o_next_offset   (o_next_offset),
        .o_var_value     (var_value),
        .o_bad_condition (o_bad_condition)
    );

    assign o_var_value = $signed(var_value);

endmodule
